@@ hdl/multi_link_element_parser_core_macros.svh @@
// Assertion macros shared by the checker of the multi-link element parser.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MULTI_LINK_ELEMENT_PARSER_CORE_MACROS_SVH
`define MULTI_LINK_ELEMENT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("multi-link element parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("multi-link element parser check failed");

// Next-cycle implication that also holds across reset.
`define MLEP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("multi-link element parser check failed");

`endif

@@ hdl/mlep_pkg.sv @@
// Shared types, constants and helper functions of the multi-link element parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mlep_pkg;

    localparam logic [7:0] C_MAX_BODY    = 8'd255;
    localparam int         C_QUEUE_DEPTH = 4;
    localparam int         C_QPTR_W      = $clog2(C_QUEUE_DEPTH);

    localparam logic [7:0] C_EXT_ID_RST  = 8'd107;
    localparam logic [2:0] C_VARIANT_RST = 3'd0;
    localparam logic [7:0] C_PSID_RST    = 8'd0;
    localparam logic [3:0] C_LIMIT_RST   = 4'd4;

    localparam logic [1:0] C_REG_EXT_ID  = 2'd0;
    localparam logic [1:0] C_REG_VARIANT = 2'd1;
    localparam logic [1:0] C_REG_PSID    = 2'd2;
    localparam logic [1:0] C_REG_LIMIT   = 2'd3;

    localparam logic [2:0] C_ST_OK          = 3'd0;
    localparam logic [2:0] C_ST_SHORT       = 3'd1;
    localparam logic [2:0] C_ST_BAD_EXT     = 3'd2;
    localparam logic [2:0] C_ST_NOT_BASIC   = 3'd3;
    localparam logic [2:0] C_ST_NO_MLD      = 3'd4;
    localparam logic [2:0] C_ST_COMMON_SMALL = 3'd5;
    localparam logic [2:0] C_ST_COMMON_OVER = 3'd6;
    localparam logic [2:0] C_ST_MLD_BAD     = 3'd7;

    localparam logic [7:0] C_MIN_BODY      = 8'd10;
    localparam logic [7:0] C_MIN_COMMON    = 8'd7;
    localparam logic [7:0] C_MIN_SUB_LEN   = 8'd9;
    localparam logic [7:0] C_MIN_STA_INFO  = 8'd7;
    localparam int         C_CTRL_MLD_BIT  = 4;
    localparam int         C_STA_LINK_BIT  = 5;
    localparam int         C_GROUP_BIT     = 40;

    typedef struct packed {
        logic        has_link;
        logic        has_sum;
        logic [2:0]  status;
        logic [47:0] mld_address;
        logic [47:0] link_address;
        logic [3:0]  link_number;
        logic [3:0]  links_found;
        logic        links_cut;
    } t_rec;

    typedef struct packed {
        logic [7:0] ext_id;
        logic [2:0] variant;
        logic [7:0] psid;
        logic [3:0] limit;
    } t_cfg;

    function automatic logic addr_usable(input logic [47:0] a);
        addr_usable = !a[C_GROUP_BIT] && (a != 48'd0);
    endfunction

endpackage

@@ hdl/mlep_front.sv @@
// Front part: accepts body bytes, tracks the element and subelement state
// and builds one queue entry per byte that yields a record. Uses mlep_pkg.
module mlep_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_final,
    input  mlep_pkg::t_cfg    i_cfg,
    output mlep_pkg::t_rec    o_rec,
    output logic              o_push
);

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_common, n_common;
    logic [2:0]  r_fail, n_fail;
    logic [47:0] r_mld, n_mld;
    logic [8:0]  r_sub_start, n_sub_start;
    logic [7:0]  r_sub_kind, n_sub_kind;
    logic [7:0]  r_sub_len, n_sub_len;
    logic [7:0]  r_sta_ctrl, n_sta_ctrl;
    logic [7:0]  r_sta_info, n_sta_info;
    logic [47:0] r_link, n_link;
    logic [3:0]  r_total, n_total;
    logic        r_trunc, n_trunc;

    logic [7:0]  w_rel;
    logic        w_walk;
    logic        w_done;
    logic        w_link;
    logic [2:0]  w_status;

    always_comb begin
        n_pos       = r_pos;
        n_ctrl      = r_ctrl;
        n_common    = r_common;
        n_fail      = r_fail;
        n_mld       = r_mld;
        n_sub_start = r_sub_start;
        n_sub_kind  = r_sub_kind;
        n_sub_len   = r_sub_len;
        n_sta_ctrl  = r_sta_ctrl;
        n_sta_info  = r_sta_info;
        n_link      = r_link;
        n_total     = r_total;
        n_trunc     = r_trunc;
        w_link      = 1'b0;
        w_done      = 1'b0;
        w_rel       = r_pos - r_sub_start[7:0];
        w_walk      = (r_pos >= 8'd4) && ({1'b0, r_pos} >= (9'd3 + {1'b0, r_common}))
                      && (r_fail == mlep_pkg::C_ST_OK);

        if (r_pos < mlep_pkg::C_MAX_BODY) begin
            case (r_pos)
                8'd0: begin
                    if (i_byte != i_cfg.ext_id) begin
                        n_fail = mlep_pkg::C_ST_BAD_EXT;
                    end
                end
                8'd1: begin
                    n_ctrl = i_byte;
                end
                8'd2: begin
                    if (r_ctrl[2:0] != i_cfg.variant) begin
                        if (n_fail == mlep_pkg::C_ST_OK) n_fail = mlep_pkg::C_ST_NOT_BASIC;
                    end
                    if (!r_ctrl[mlep_pkg::C_CTRL_MLD_BIT]) begin
                        if (n_fail == mlep_pkg::C_ST_OK) n_fail = mlep_pkg::C_ST_NO_MLD;
                    end
                end
                8'd3: begin
                    n_common    = i_byte;
                    n_sub_start = 9'd3 + {1'b0, i_byte};
                    if (i_byte < mlep_pkg::C_MIN_COMMON) begin
                        if (n_fail == mlep_pkg::C_ST_OK) begin
                            n_fail = mlep_pkg::C_ST_COMMON_SMALL;
                        end
                    end
                end
                default: begin
                    if (r_pos <= 8'd9) begin
                        n_mld = {r_mld[39:0], i_byte};
                    end
                end
            endcase

            if (w_walk) begin
                case (w_rel)
                    8'd0:    n_sub_kind = i_byte;
                    8'd1:    n_sub_len  = i_byte;
                    8'd2:    n_sta_ctrl = i_byte;
                    8'd3:    n_sta_ctrl = r_sta_ctrl;
                    8'd4:    n_sta_info = i_byte;
                    default: begin
                        if (w_rel <= 8'd10) begin
                            n_link = {r_link[39:0], i_byte};
                        end
                    end
                endcase
                w_done = (w_rel != 8'd0) && ({1'b0, w_rel} == ({1'b0, n_sub_len} + 9'd1));
                if (w_done) begin
                    if ((n_sub_kind == i_cfg.psid) && (n_sub_len >= mlep_pkg::C_MIN_SUB_LEN)
                        && n_sta_ctrl[mlep_pkg::C_STA_LINK_BIT]
                        && (n_sta_info >= mlep_pkg::C_MIN_STA_INFO)
                        && mlep_pkg::addr_usable(n_link) && mlep_pkg::addr_usable(n_mld)) begin
                        if (r_total < i_cfg.limit) begin
                            n_total = r_total + 4'd1;
                            w_link  = 1'b1;
                        end else begin
                            n_trunc = 1'b1;
                        end
                    end
                    n_sub_start = {1'b0, r_pos} + 9'd1;
                end
            end
            n_pos = r_pos + 8'd1;
        end

        if (n_pos < mlep_pkg::C_MIN_BODY) begin
            w_status = mlep_pkg::C_ST_SHORT;
        end else if (n_fail != mlep_pkg::C_ST_OK) begin
            w_status = n_fail;
        end else if ((9'd3 + {1'b0, n_common}) > {1'b0, n_pos}) begin
            w_status = mlep_pkg::C_ST_COMMON_OVER;
        end else if (!mlep_pkg::addr_usable(n_mld)) begin
            w_status = mlep_pkg::C_ST_MLD_BAD;
        end else begin
            w_status = mlep_pkg::C_ST_OK;
        end
    end

    always_comb begin
        o_rec.has_link     = w_link;
        o_rec.has_sum      = i_final;
        o_rec.status       = w_status;
        o_rec.mld_address  = (!i_final || (w_status == mlep_pkg::C_ST_OK)) ? n_mld : 48'd0;
        o_rec.link_address = n_link;
        o_rec.link_number  = n_sta_ctrl[3:0];
        o_rec.links_found  = n_total;
        o_rec.links_cut    = n_trunc;
        o_push             = i_accept && (w_link || i_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final)) begin
            r_pos       <= '0;
            r_ctrl      <= '0;
            r_common    <= '0;
            r_fail      <= mlep_pkg::C_ST_OK;
            r_mld       <= '0;
            r_sub_start <= '0;
            r_sub_kind  <= '0;
            r_sub_len   <= '0;
            r_sta_ctrl  <= '0;
            r_sta_info  <= '0;
            r_link      <= '0;
            r_total     <= '0;
            r_trunc     <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_ctrl      <= n_ctrl;
            r_common    <= n_common;
            r_fail      <= n_fail;
            r_mld       <= n_mld;
            r_sub_start <= n_sub_start;
            r_sub_kind  <= n_sub_kind;
            r_sub_len   <= n_sub_len;
            r_sta_ctrl  <= n_sta_ctrl;
            r_sta_info  <= n_sta_info;
            r_link      <= n_link;
            r_total     <= n_total;
            r_trunc     <= n_trunc;
        end
    end

endmodule

@@ hdl/mlep_queue.sv @@
// Short queue of pending record entries between the front and back parts.
// Uses the entry type and depth from mlep_pkg.
module mlep_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mlep_pkg::t_rec    i_rec,
    input  logic              i_pop,
    output mlep_pkg::t_rec    o_rec,
    output logic              o_valid,
    output logic              o_full
);

    mlep_pkg::t_rec r_mem [mlep_pkg::C_QUEUE_DEPTH];
    logic [mlep_pkg::C_QPTR_W-1:0] r_wr, r_rd;
    logic [mlep_pkg::C_QPTR_W:0]   r_count;
    logic w_push, w_pop;

    assign o_rec   = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (mlep_pkg::C_QPTR_W + 1)'(mlep_pkg::C_QUEUE_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + (mlep_pkg::C_QPTR_W)'(1);
            if (w_pop)  r_rd <= r_rd + (mlep_pkg::C_QPTR_W)'(1);
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (mlep_pkg::C_QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (mlep_pkg::C_QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/mlep_back.sv @@
// Back part: takes queue entries and sends their link and summary beats.
// Uses the entry type from mlep_pkg.
module mlep_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlep_pkg::t_rec    i_rec,
    input  logic              i_valid,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic              o_kind,
    output logic [2:0]        o_status,
    output logic [47:0]       o_mld,
    output logic [47:0]       o_link,
    output logic [3:0]        o_number,
    output logic [3:0]        o_found,
    output logic              o_cut,
    output logic              o_last
);

    mlep_pkg::t_rec r_rec;
    logic r_link_pend, r_sum_pend;
    logic w_busy, w_fire, w_final_beat, w_take;

    assign w_busy       = r_link_pend || r_sum_pend;
    assign w_fire       = w_busy && i_tready;
    assign w_final_beat = !(r_link_pend && r_sum_pend);
    assign w_take       = !w_busy || (w_fire && w_final_beat);
    assign o_pop        = w_take && i_valid;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_pend <= 1'b0;
            r_sum_pend  <= 1'b0;
        end else if (w_take) begin
            r_link_pend <= i_valid && i_rec.has_link;
            r_sum_pend  <= i_valid && i_rec.has_sum;
        end else if (w_fire) begin
            r_link_pend <= 1'b0;
        end
    end

    assign o_tvalid = w_busy;
    assign o_kind   = !r_link_pend;
    assign o_status = r_link_pend ? mlep_pkg::C_ST_OK : r_rec.status;
    assign o_mld    = r_rec.mld_address;
    assign o_link   = r_link_pend ? r_rec.link_address : 48'd0;
    assign o_number = r_link_pend ? r_rec.link_number : 4'd0;
    assign o_found  = r_rec.links_found;
    assign o_cut    = r_rec.links_cut;
    assign o_last   = !r_link_pend;

endmodule

@@ hdl/multi_link_element_parser_core.sv @@
// Top level of the multi-link element parser: front, record queue and back.
// Depends on mlep_pkg, mlep_front, mlep_queue and mlep_back.
//
// The element body enters on the s_axis channel one byte per beat, starting
// at the extension ID byte, with tlast on the final byte. Records leave on
// the m_axis channel: tuser 0 is a link record, tuser 1 the summary that
// ends the element, which also carries tlast.
// The front takes one byte every cycle unless the queue is full; a byte that
// completes a usable Per-STA subelement and also ends the element yields two
// records, which leave in two consecutive beats. A record passes through the
// queue and then the back's record register before it shows on m_axis.
// A four-entry queue lies between the front and the back, so the front keeps
// taking bytes while the receiver stalls; s_axis_tready drops only when that
// queue is full.
// Reset clears the parse state and the queue and loads the default register
// values. Registers are written through i_cfg_we, i_cfg_index and i_cfg_data
// while no element is in progress: a user's rule, not enforced by the block.
module multi_link_element_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] body_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [50:3] mld_address, [98:51] link_address,
    // [102:99] link_number, [106:103] links_found, [107] links_cut, rest zero
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tuser,   // [0] record_kind
    output logic         m_axis_tlast
);

    mlep_pkg::t_cfg r_cfg;
    mlep_pkg::t_rec w_front_rec, w_queue_rec;
    logic w_accept, w_push, w_pop, w_q_valid, w_q_full;
    logic [2:0]  w_status;
    logic [47:0] w_mld, w_link;
    logic [3:0]  w_number, w_found;
    logic        w_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_id  <= mlep_pkg::C_EXT_ID_RST;
            r_cfg.variant <= mlep_pkg::C_VARIANT_RST;
            r_cfg.psid    <= mlep_pkg::C_PSID_RST;
            r_cfg.limit   <= mlep_pkg::C_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlep_pkg::C_REG_EXT_ID:  r_cfg.ext_id  <= i_cfg_data;
                mlep_pkg::C_REG_VARIANT: r_cfg.variant <= i_cfg_data[2:0];
                mlep_pkg::C_REG_PSID:    r_cfg.psid    <= i_cfg_data;
                mlep_pkg::C_REG_LIMIT:   r_cfg.limit   <= i_cfg_data[3:0];
                default:                 r_cfg         <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && !w_q_full;

    mlep_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_byte  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .i_cfg   (r_cfg),
        .o_rec   (w_front_rec),
        .o_push  (w_push)
    );

    mlep_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_rec  (w_front_rec),
        .i_pop  (w_pop),
        .o_rec  (w_queue_rec),
        .o_valid(w_q_valid),
        .o_full (w_q_full)
    );

    mlep_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_queue_rec),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_status(w_status),
        .o_mld   (w_mld),
        .o_link  (w_link),
        .o_number(w_number),
        .o_found (w_found),
        .o_cut   (w_cut),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_cut, w_found, w_number, w_link, w_mld, w_status};

endmodule

@@ hdl/mlep_checker.sv @@
// Port-level checker for the multi-link element parser, bound to the top level.
// Depends on mlep_pkg and multi_link_element_parser_core_macros.svh.
`include "multi_link_element_parser_core_macros.svh"

module mlep_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_tvalid,
    input logic         i_m_tready,
    input logic [111:0] i_m_tdata,
    input logic         i_m_tuser,
    input logic         i_m_tlast
);

    logic        w_stall;
    logic        w_bad_sum;
    logic        w_link_beat;
    logic [2:0]  w_status;
    logic [47:0] w_mld;
    logic [3:0]  w_found;

    assign w_status    = i_m_tdata[2:0];
    assign w_mld       = i_m_tdata[50:3];
    assign w_found     = i_m_tdata[106:103];
    assign w_stall     = i_m_tvalid && !i_m_tready;
    assign w_bad_sum   = i_m_tvalid && i_m_tuser && (w_status != mlep_pkg::C_ST_OK);
    assign w_link_beat = i_m_tvalid && !i_m_tuser;

    `MLEP_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !i_m_tvalid)
    `MLEP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, i_m_tvalid && $stable(i_m_tdata))
    `MLEP_ASSERT_NOW(a_last_is_summary, i_clk, i_rst_n, i_m_tvalid, i_m_tuser == i_m_tlast)
    `MLEP_ASSERT_NOW(a_fail_no_mld, i_clk, i_rst_n, w_bad_sum, w_mld == 48'd0)
    `MLEP_ASSERT_NOW(a_link_counted, i_clk, i_rst_n, w_link_beat, (w_status == mlep_pkg::C_ST_OK) && (w_found != 4'd0))

endmodule

bind multi_link_element_parser_core mlep_checker u_mlep_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_tvalid(m_axis_tvalid),
    .i_m_tready(m_axis_tready),
    .i_m_tdata (m_axis_tdata),
    .i_m_tuser (m_axis_tuser),
    .i_m_tlast (m_axis_tlast)
);

@@ tb/multi_link_element_parser_core_test.sv @@
// Self-checking testbench for multi_link_element_parser_core: streams element bodies byte by
// byte with random bursts and output stalls, predicts every record and compares it in order.
// Depends on mlep_pkg and the multi_link_element_parser_core RTL.
module multi_link_element_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS_PER_PHASE = 95;
    localparam int          PHASES          = 6;
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam logic        KIND_LINK       = 1'b0;
    localparam logic        KIND_SUMMARY    = 1'b1;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_TOGGLE} t_ready_mode;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [47:0] mld;
        logic [47:0] link;
        logic [3:0]  number;
        logic [3:0]  found;
        logic        cut;
        logic        last;
    } t_element_record;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] status;
    } t_directed_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = mlep_pkg::C_REG_EXT_ID;
    logic [7:0]   i_cfg_data = 8'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    logic [7:0]  cfg_ext_id;
    logic [2:0]  cfg_variant;
    logic [7:0]  cfg_psid;
    logic [3:0]  cfg_limit;

    logic [7:0]  parse_pos;
    logic [15:0] ctl_word;
    logic [7:0]  cinfo_len;
    logic [2:0]  fail_code;
    logic [47:0] mld_addr;
    logic [7:0]  sub_start;
    logic [7:0]  sub_id;
    logic [7:0]  sub_len;
    logic [15:0] sta_ctl;
    logic [7:0]  sta_info_len;
    logic [47:0] link_addr;
    logic [3:0]  links_sent;
    logic        cut_flag;

    t_element_record fresh_q[$];
    t_element_record expected_q[$];
    logic [7:0]      body_q[$];
    int              mismatches = 0;
    int              random_items = 0;
    int              burst_left = 0;
    int unsigned     cycle_count = 0;

    t_directed_row directed_rows[23] = '{
        '{8'h00, 1'b1, 1'b1, mlep_pkg::C_ST_SHORT},
        '{8'hFF, 1'b1, 1'b1, mlep_pkg::C_ST_SHORT},
        '{8'h6B, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h10, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h00, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h07, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h00, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h11, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h22, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h33, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h44, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h55, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h00, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h09, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h2F, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hFF, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h07, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'h02, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hAA, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hBB, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hCC, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hDD, 1'b0, 1'b0, mlep_pkg::C_ST_OK},
        '{8'hEE, 1'b1, 1'b0, mlep_pkg::C_ST_OK}
    };

    multi_link_element_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic station_addr_ok(input logic [47:0] a);
        return !a[mlep_pkg::C_GROUP_BIT] && (a != 48'd0);
    endfunction

    function automatic void flag_failure(input logic [2:0] code);
        if (fail_code == mlep_pkg::C_ST_OK) fail_code = code;
    endfunction

    function automatic void clear_parse_state();
        parse_pos = 8'd0;
        ctl_word = 16'd0;
        cinfo_len = 8'd0;
        fail_code = mlep_pkg::C_ST_OK;
        mld_addr = 48'd0;
        sub_start = 8'd0;
        sub_id = 8'd0;
        sub_len = 8'd0;
        sta_ctl = 16'd0;
        sta_info_len = 8'd0;
        link_addr = 48'd0;
        links_sent = 4'd0;
        cut_flag = 1'b0;
    endfunction

    // Advances the parse state by one body byte and leaves the records it causes in fresh_q.
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        int              p;
        int              rel;
        int              body_len;
        logic [2:0]      st;
        t_element_record rec;
        fresh_q.delete();
        if (parse_pos < mlep_pkg::C_MAX_BODY) begin
            p = int'(parse_pos);
            if (p == 0) begin
                if (b != cfg_ext_id) flag_failure(mlep_pkg::C_ST_BAD_EXT);
            end else if (p == 1) begin
                ctl_word = {8'd0, b};
            end else if (p == 2) begin
                ctl_word[15:8] = b;
                if (ctl_word[2:0] != cfg_variant) flag_failure(mlep_pkg::C_ST_NOT_BASIC);
                if (!ctl_word[mlep_pkg::C_CTRL_MLD_BIT]) flag_failure(mlep_pkg::C_ST_NO_MLD);
            end else if (p == 3) begin
                cinfo_len = b;
                if (b < mlep_pkg::C_MIN_COMMON) flag_failure(mlep_pkg::C_ST_COMMON_SMALL);
                sub_start = 8'(3 + int'(b));
            end else if (p <= 9) begin
                mld_addr = {mld_addr[39:0], b};
            end
            if (p >= 4 && p >= 3 + int'(cinfo_len) && fail_code == mlep_pkg::C_ST_OK) begin
                rel = p - int'(sub_start);
                if (rel == 0) sub_id = b;
                else if (rel == 1) sub_len = b;
                else if (rel == 2) sta_ctl = {8'd0, b};
                else if (rel == 3) sta_ctl = sta_ctl | {b, 8'd0};
                else if (rel == 4) sta_info_len = b;
                else if (rel <= 10) link_addr = {link_addr[39:0], b};
                if (rel >= 1 && rel == 1 + int'(sub_len)) begin
                    if (sub_id == cfg_psid && sub_len >= mlep_pkg::C_MIN_SUB_LEN &&
                            sta_ctl[mlep_pkg::C_STA_LINK_BIT] &&
                            sta_info_len >= mlep_pkg::C_MIN_STA_INFO &&
                            station_addr_ok(link_addr) && station_addr_ok(mld_addr)) begin
                        if (links_sent < cfg_limit) begin
                            links_sent = links_sent + 4'd1;
                            rec = '0;
                            rec.kind = KIND_LINK;
                            rec.status = mlep_pkg::C_ST_OK;
                            rec.mld = mld_addr;
                            rec.link = link_addr;
                            rec.number = sta_ctl[3:0];
                            rec.found = links_sent;
                            rec.cut = cut_flag;
                            fresh_q.push_back(rec);
                        end else begin
                            cut_flag = 1'b1;
                        end
                    end
                    sub_start = 8'(p + 1);
                end
            end
            parse_pos = 8'(p + 1);
        end
        if (fin) begin
            body_len = int'(parse_pos);
            if (body_len < int'(mlep_pkg::C_MIN_BODY)) st = mlep_pkg::C_ST_SHORT;
            else if (fail_code != mlep_pkg::C_ST_OK) st = fail_code;
            else if (3 + int'(cinfo_len) > body_len) st = mlep_pkg::C_ST_COMMON_OVER;
            else if (!station_addr_ok(mld_addr)) st = mlep_pkg::C_ST_MLD_BAD;
            else st = mlep_pkg::C_ST_OK;
            rec = '0;
            rec.kind = KIND_SUMMARY;
            rec.status = st;
            rec.mld = (st == mlep_pkg::C_ST_OK) ? mld_addr : 48'd0;
            rec.found = links_sent;
            rec.cut = cut_flag;
            rec.last = 1'b1;
            fresh_q.push_back(rec);
            clear_parse_state();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [2:0] typed_status);
        logic            taken;
        t_element_record summary;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        parse_byte(b, fin);
        if (typed) begin
            summary = '0;
            summary.kind = KIND_SUMMARY;
            summary.status = typed_status;
            summary.last = 1'b1;
            expected_q.push_back(summary);
        end else begin
            foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Mostly well-formed bodies with random content, plus noise, broken and overlong ones.
    task automatic make_element();
        int         style;
        int         clen;
        int         nsub;
        int         slen;
        int         target;
        logic       addr_zero;
        logic [15:0] ctl;
        logic [7:0] content;
        body_q.delete();
        style = $urandom_range(0, 99);
        if (style < 10) begin
            repeat ($urandom_range(1, 24)) body_q.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1) body_q[0] = cfg_ext_id;
            return;
        end
        body_q.push_back(style < 14 ? 8'($urandom) : cfg_ext_id);
        ctl = 16'($urandom);
        if (style >= 18) ctl[2:0] = cfg_variant;
        if (style >= 22) ctl[mlep_pkg::C_CTRL_MLD_BIT] = 1'b1;
        body_q.push_back(ctl[7:0]);
        body_q.push_back(ctl[15:8]);
        if (style < 27) clen = $urandom_range(0, 255);
        else if ($urandom_range(0, 3) == 0) clen = $urandom_range(8, 14);
        else clen = 7;
        body_q.push_back(8'(clen));
        for (int k = 1; k < clen && k < 20; k++) begin
            content = 8'($urandom);
            if (k == 1 && style >= 31) content[0] = 1'b0;
            if (style == 31 || style == 32) content = 8'h00;
            body_q.push_back(content);
        end
        nsub = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
        repeat (nsub) begin
            if ($urandom_range(0, 3) != 0) begin
                body_q.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : cfg_psid);
                slen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(9, 13);
            end else begin
                body_q.push_back(8'($urandom));
                slen = $urandom_range(0, 6);
            end
            body_q.push_back(8'(slen));
            addr_zero = ($urandom_range(0, 15) == 0);
            for (int k = 0; k < slen; k++) begin
                content = 8'($urandom);
                if (k == 0 && $urandom_range(0, 7) != 0) begin
                    content[mlep_pkg::C_STA_LINK_BIT] = 1'b1;
                end
                if (k == 2 && $urandom_range(0, 7) != 0) content = 8'($urandom_range(7, 9));
                if (k == 3 && $urandom_range(0, 7) != 0) content[0] = 1'b0;
                if (k >= 3 && k <= 8 && addr_zero) content = 8'h00;
                body_q.push_back(content);
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                if (body_q.size() > 1) void'(body_q.pop_back());
            end
        end
        if ($urandom_range(0, 49) == 0) begin
            target = $urandom_range(256, 280);
            while (body_q.size() < target) body_q.push_back(8'($urandom));
        end
    endtask

    task automatic send_element();
        foreach (body_q[i]) begin
            send_byte(body_q[i], i == body_q.size() - 1, 1'b0, mlep_pkg::C_ST_OK);
            random_items++;
        end
    endtask

    task automatic drain_records();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] ext_id, input logic [2:0] variant_val,
                                  input logic [7:0] psid, input logic [3:0] limit);
        i_cfg_we <= 1'b1;
        i_cfg_index <= mlep_pkg::C_REG_EXT_ID;
        i_cfg_data <= ext_id;
        @(posedge i_clk);
        i_cfg_index <= mlep_pkg::C_REG_VARIANT;
        i_cfg_data <= {5'd0, variant_val};
        @(posedge i_clk);
        i_cfg_index <= mlep_pkg::C_REG_PSID;
        i_cfg_data <= psid;
        @(posedge i_clk);
        i_cfg_index <= mlep_pkg::C_REG_LIMIT;
        i_cfg_data <= {4'd0, limit};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_ext_id = ext_id;
        cfg_variant = variant_val;
        cfg_psid = psid;
        cfg_limit = limit;
    endtask

    function automatic void compare_field(input string name, input logic [47:0] want,
                                          input logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge i_clk) begin
        t_element_record got;
        t_element_record want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.status = m_axis_tdata[2:0];
            got.mld = m_axis_tdata[50:3];
            got.link = m_axis_tdata[98:51];
            got.number = m_axis_tdata[102:99];
            got.found = m_axis_tdata[106:103];
            got.cut = m_axis_tdata[107];
            got.last = m_axis_tlast;
            if (expected_q.size() == 0) begin
                $error("unexpected record: kind %0d, status %0d", got.kind, got.status);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                compare_field("record_kind", 48'(want.kind), 48'(got.kind));
                compare_field("status", 48'(want.status), 48'(got.status));
                compare_field("mld_address", want.mld, got.mld);
                compare_field("link_address", want.link, got.link);
                compare_field("link_number", 48'(want.number), 48'(got.number));
                compare_field("links_found", 48'(want.found), 48'(got.found));
                compare_field("links_cut", 48'(want.cut), 48'(got.cut));
                compare_field("last_record", 48'(want.last), 48'(got.last));
            end
        end
    end

    initial begin : receiver
        t_ready_mode mode;
        int          span;
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default:      m_axis_tready <= !m_axis_tready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        cfg_ext_id = mlep_pkg::C_EXT_ID_RST;
        cfg_variant = mlep_pkg::C_VARIANT_RST;
        cfg_psid = mlep_pkg::C_PSID_RST;
        cfg_limit = mlep_pkg::C_LIMIT_RST;
        clear_parse_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].status);
        end
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain_records();
                case (phase)
                    1: write_settings(8'h00, 3'd7, 8'hFF, 4'd0);
                    2: write_settings(8'hFF, 3'd0, 8'h00, 4'd15);
                    3: write_settings(8'h6B, 3'd3, 8'hDD, 4'd1);
                    default: write_settings(8'($urandom), 3'($urandom), 8'($urandom),
                                            4'($urandom));
                endcase
            end
            while (random_items < (phase + 1) * ITEMS_PER_PHASE) begin
                make_element();
                send_element();
            end
        end
        drain_records();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/mlep_pkg.sv
hdl/mlep_front.sv
hdl/mlep_queue.sv
hdl/mlep_back.sv
hdl/multi_link_element_parser_core.sv
hdl/mlep_checker.sv
tb/multi_link_element_parser_core_test.sv
